### sv/ps2mct_pkg.sv
// Shared constants and types for the PS/2 mouse packet cursor tracker.
package ps2mct_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int POS_W       = 32;
  localparam int SIZE_W      = 16;
  localparam int OUT_FIELD_W = 2 * POS_W + 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic              CLAMP_ENABLE_RST  = 1'b1;
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 16'd1024;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 16'd768;

  localparam int STATUS_OBF_BIT = 0;
  localparam int STATUS_AUX_BIT = 5;
  localparam int HDR_XSIGN_BIT  = 4;
  localparam int HDR_YSIGN_BIT  = 5;
  localparam int HDR_XOVF_BIT   = 6;
  localparam int HDR_YOVF_BIT   = 7;

  localparam logic [1:0] BYTE_HEADER = 2'd0;
  localparam logic [1:0] BYTE_XDELTA = 2'd1;
  localparam logic [1:0] BYTE_YDELTA = 2'd2;

  typedef struct packed {
    logic             middle;
    logic             right;
    logic             left;
    logic [POS_W-1:0] cursor_y;
    logic [POS_W-1:0] cursor_x;
  } result_t;

endpackage

### sv/ps2_mouse_packet_cursor_tracker_unit.sv
// PS/2 mouse packet decoder and cursor tracker, top level.
//
// Each transfer on the s_ side carries one controller status byte and one
// data byte. Bytes whose status shows output-full and auxiliary data are
// gathered into three-byte packets. Every packet without an overflow bit
// updates the buttons and the cursor and produces one transfer on the m_
// side; all other bytes produce nothing.
// The block takes one input transfer per cycle while no result is stalled.
// A byte is registered on acceptance and processed from the input register;
// a result is registered and shown on m_tvalid. The result register frees
// up in the cycle it is taken, so results can leave back to back. While the
// receiver stalls a pending result, the next byte waits in the input
// register and s_tready drops once it is full. Configuration writes on cfg_
// are always accepted and take effect from the next packet completed; the
// user must issue them only while the block is idle; it is not enforced.
// Reset clears the packet assembly, the cursor and the buttons, empties both
// registers and loads the screen size 1024 by 768 with clamping enabled.
module ps2_mouse_packet_cursor_tracker_unit
  import ps2mct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // status_byte[7:0], data_byte[15:8]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // cursor_x[31:0], cursor_y[63:32],
                                            // left_pressed[64], right_pressed[65],
                                            // middle_pressed[66], zeros above
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  logic              clamp_enable;
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;

  logic       in_valid;
  logic [7:0] in_status;
  logic [7:0] in_data;

  logic [1:0]       byte_position, byte_position_next;
  logic [7:0]       header_byte, header_byte_next;
  logic [7:0]       x_delta_byte, x_delta_byte_next;
  logic [POS_W-1:0] position_x, position_x_next;
  logic [POS_W-1:0] position_y, position_y_next;
  logic [2:0]       button_bits, button_bits_next;

  logic             out_valid;
  result_t          out_data;

  logic             proc;
  logic             taken;
  logic             emit;
  logic [POS_W-1:0] dx, dy, sum_x, sum_y;

  function automatic logic [POS_W-1:0] clamp_axis(input logic [POS_W-1:0] pos,
                                                  input logic [SIZE_W-1:0] size);
    logic [POS_W-1:0] limit;
    limit = (size == '0) ? '0 : POS_W'(size - SIZE_W'(1));
    if (pos[POS_W-1]) begin
      return '0;
    end else if (pos > limit) begin
      return limit;
    end
    return pos;
  endfunction

  assign cfg_ready = 1'b1;
  assign proc      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || proc;
  assign taken     = in_status[STATUS_OBF_BIT] && in_status[STATUS_AUX_BIT];

  assign dx    = {{(POS_W-8){header_byte[HDR_XSIGN_BIT]}}, x_delta_byte};
  assign dy    = {{(POS_W-8){header_byte[HDR_YSIGN_BIT]}}, in_data};
  assign sum_x = position_x + dx;
  assign sum_y = position_y - dy;

  always_comb begin
    byte_position_next = byte_position;
    header_byte_next   = header_byte;
    x_delta_byte_next  = x_delta_byte;
    position_x_next    = position_x;
    position_y_next    = position_y;
    button_bits_next   = button_bits;
    emit               = 1'b0;
    if (taken) begin
      priority if (byte_position == BYTE_XDELTA) begin
        x_delta_byte_next  = in_data;
        byte_position_next = BYTE_YDELTA;
      end else if (byte_position == BYTE_YDELTA) begin
        byte_position_next = BYTE_HEADER;
        if (!header_byte[HDR_XOVF_BIT] && !header_byte[HDR_YOVF_BIT]) begin
          emit             = 1'b1;
          button_bits_next = header_byte[2:0];
          if (clamp_enable) begin
            position_x_next = clamp_axis(sum_x, screen_width);
            position_y_next = clamp_axis(sum_y, screen_height);
          end else begin
            position_x_next = sum_x;
            position_y_next = sum_y;
          end
        end
      end else begin
        header_byte_next   = in_data;
        byte_position_next = BYTE_XDELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_enable  <= CLAMP_ENABLE_RST;
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLAMP_ENABLE:  clamp_enable  <= cfg_data[0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_status <= s_tdata[7:0];
      in_data   <= s_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= BYTE_HEADER;
      header_byte   <= '0;
      x_delta_byte  <= '0;
      position_x    <= '0;
      position_y    <= '0;
      button_bits   <= '0;
    end else if (proc) begin
      byte_position <= byte_position_next;
      header_byte   <= header_byte_next;
      x_delta_byte  <= x_delta_byte_next;
      position_x    <= position_x_next;
      position_y    <= position_y_next;
      button_bits   <= button_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (proc && emit) begin
      out_data.cursor_x <= position_x_next;
      out_data.cursor_y <= position_y_next;
      out_data.left     <= button_bits_next[0];
      out_data.right    <= button_bits_next[1];
      out_data.middle   <= button_bits_next[2];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_data};

endmodule

### sv/ps2mct_checker.sv
// Port-level assertions for the PS/2 mouse packet cursor tracker and their bind.
module ps2mct_checker
  import ps2mct_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or vanished while stalled");

  // A new result needs a preceding input transfer.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a preceding input transfer");

  // The padding above the result fields is always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0)
    else $error("nonzero padding in result");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mct_checker u_ps2mct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
